### rtl/multi_slot_timer_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer table
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_TIMER_TABLE_UNIT_DEFINES_SVH
`define MULTI_SLOT_TIMER_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define MSTT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("timer table check failed");

// cond must never be true outside reset
`define MSTT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("timer table forbidden condition");

`else

`define MSTT_ASSERT(label, clk, rst_n, prop)
`define MSTT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### rtl/mstt_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Command and result codes, sequencer states and the slot memory word.
// ----------------------------------------------------------------------------
package mstt_pkg;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_TALLOC  = 3'd1,
        CMD_TCANCEL = 3'd2,
        CMD_CALLOC  = 3'd3,
        CMD_START   = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_READ    = 3'd6,
        CMD_CCANCEL = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_FIRE  = 3'd0,
        KIND_GRANT = 3'd1,
        KIND_BAD   = 3'd2,
        KIND_WATCH = 3'd3,
        KIND_DONE  = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WALK = 5'b00010,
        ST_DONE = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_RDW  = 5'b10000
    } state_t;

    // One memory word per slot; timer fields and stopwatch count share it.
    typedef struct packed {
        logic [7:0] period;
        logic [7:0] remaining;
        logic [7:0] repeats;
        logic [7:0] count;
    } slot_word_t;

endpackage

### rtl/multi_slot_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Multi-slot timer table
// Table of countdown timers and stopwatches driven by a small sequencer.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A tick walks the slots one per cycle,
// held while a fire waits for the output register, through the single-port
// slot memory and then gives a done result; an allocation scans for the
// lowest free slot, one slot per cycle; a read waits in its own state for the
// registered memory read; every other command answers when it is accepted.
// Each result goes to an output register, and a stalled output holds the
// sequencer only when a new result has to be loaded.
`include "multi_slot_timer_table_unit_defines.svh"

module multi_slot_timer_table_unit
    import mstt_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [3:0] slot,
    input  logic [7:0] period,
    input  logic [7:0] repeat_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [3:0] slot_res,
    output logic [7:0] value,
    output logic       last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    state_t           state_reg, state_next;
    logic [IW-1:0]    ptr_reg, ptr_next;
    logic [SLOTS-1:0] sw_reg, sw_next;
    logic [SLOTS-1:0] live_reg, live_next;
    logic [SLOTS-1:0] run_reg, run_next;
    logic [SLOTS-1:0] en_reg, en_next;

    cmd_t             cmd_reg, cmd_next;
    logic [7:0]       per_reg, per_next;
    logic [7:0]       rep_reg, rep_next;
    logic             rsw_reg, rsw_next;

    logic             ov_reg, ov_next;
    kind_t            kind_reg, kind_next;
    logic [3:0]       slot_res_reg, slot_res_next;
    logic [7:0]       value_reg, value_next;
    logic             last_reg, last_next;

    slot_word_t       mem [SLOTS];
    slot_word_t       rd_q;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    slot_word_t       mem_wd;

    logic             out_free;
    logic             accept;
    logic             slot_ok;
    logic [IW-1:0]    cidx;

    logic             emit;
    kind_t            e_kind;
    logic [3:0]       e_slot;
    logic [7:0]       e_val;
    logic             e_last;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign slot_ok  = 32'(slot) < SLOTS;
    assign cidx     = slot_ok ? IW'(slot) : '0;

    always_comb
    begin
        slot_word_t w;
        logic [7:0] rem_dec;

        state_next = state_reg;
        ptr_next   = ptr_reg;
        sw_next    = sw_reg;
        live_next  = live_reg;
        run_next   = run_reg;
        en_next    = en_reg;
        cmd_next   = cmd_reg;
        per_next   = per_reg;
        rep_next   = rep_reg;
        rsw_next   = rsw_reg;
        mem_we     = 1'b0;
        mem_wa     = ptr_reg;
        mem_wd     = '0;
        emit       = 1'b0;
        e_kind     = KIND_BAD;
        e_slot     = '0;
        e_val      = '0;
        e_last     = 1'b0;
        w          = rd_q;
        rem_dec    = rd_q.remaining - 8'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd_t'(cmd);
                    per_next = period;
                    rep_next = repeat_count;
                    e_last   = 1'b1;
                    case (cmd_t'(cmd))
                        CMD_TICK:
                        begin
                            ptr_next   = '0;
                            state_next = ST_WALK;
                        end
                        CMD_TALLOC:
                        begin
                            if (period == 8'd0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_CALLOC:
                        begin
                            ptr_next   = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_TCANCEL:
                        begin
                            emit = 1'b1;
                            if (slot_ok && live_reg[cidx])
                            begin
                                live_next[cidx] = 1'b0;
                                sw_next[cidx]   = 1'b0;
                                run_next[cidx]  = 1'b0;
                                en_next[cidx]   = 1'b0;
                                e_kind          = KIND_DONE;
                            end
                        end
                        CMD_START:
                        begin
                            emit = 1'b1;
                            if (slot_ok && sw_reg[cidx])
                            begin
                                // only the count matters in a stopwatch word
                                mem_we         = 1'b1;
                                mem_wa         = cidx;
                                mem_wd         = '0;
                                run_next[cidx] = 1'b1;
                                e_kind         = KIND_DONE;
                            end
                        end
                        CMD_STOP:
                        begin
                            emit = 1'b1;
                            if (slot_ok && sw_reg[cidx])
                            begin
                                run_next[cidx] = 1'b0;
                                e_kind         = KIND_DONE;
                            end
                        end
                        CMD_CCANCEL:
                        begin
                            emit = 1'b1;
                            if (slot_ok && sw_reg[cidx])
                            begin
                                live_next[cidx] = 1'b0;
                                sw_next[cidx]   = 1'b0;
                                run_next[cidx]  = 1'b0;
                                en_next[cidx]   = 1'b0;
                                e_kind          = KIND_DONE;
                            end
                        end
                        CMD_READ:
                        begin
                            ptr_next   = cidx;
                            rsw_next   = slot_ok && sw_reg[cidx];
                            state_next = ST_RDW;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (sw_reg[ptr_reg])
                begin
                    if (run_reg[ptr_reg] && en_reg[ptr_reg])
                    begin
                        w.count = rd_q.count + 8'd1;
                        mem_we  = 1'b1;
                    end
                end
                else if (live_reg[ptr_reg])
                begin
                    mem_we      = 1'b1;
                    w.remaining = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        e_kind = KIND_FIRE;
                        e_slot = 4'(ptr_reg);
                        emit   = out_free;
                        mem_we = out_free;
                        if (rd_q.repeats == 8'd1)
                        begin
                            live_next[ptr_reg] = !out_free;
                        end
                        else
                        begin
                            if (rd_q.repeats > 8'd1)
                            begin
                                w.repeats = rd_q.repeats - 8'd1;
                            end
                            w.remaining = rd_q.period;
                        end
                    end
                end
                mem_wd = w;
                // hold on a pending fire until the output register frees up
                if (!(live_reg[ptr_reg] && !sw_reg[ptr_reg] && rem_dec == 8'd0
                      && !out_free))
                begin
                    if (ptr_reg == LAST_SLOT)
                    begin
                        ptr_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IW'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_DONE;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                e_last = 1'b1;
                if (!sw_reg[ptr_reg] && !live_reg[ptr_reg])
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_kind     = KIND_GRANT;
                        e_slot     = 4'(ptr_reg);
                        mem_we     = 1'b1;
                        state_next = ST_IDLE;
                        if (cmd_reg == CMD_TALLOC)
                        begin
                            mem_wd.period      = per_reg;
                            mem_wd.remaining   = per_reg;
                            mem_wd.repeats     = rep_reg;
                            live_next[ptr_reg] = 1'b1;
                        end
                        else
                        begin
                            sw_next[ptr_reg]  = 1'b1;
                            en_next[ptr_reg]  = 1'b1;
                            run_next[ptr_reg] = 1'b0;
                        end
                    end
                end
                else if (ptr_reg == LAST_SLOT)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + IW'(1);
                end
            end

            ST_RDW:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_WATCH;
                    e_val      = rsw_reg ? rd_q.count : 8'd0;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // free the whole slot when its last repeat fires
        if (state_reg == ST_WALK && !sw_reg[ptr_reg] && live_reg[ptr_reg]
            && rem_dec == 8'd0 && rd_q.repeats == 8'd1 && out_free)
        begin
            run_next[ptr_reg] = 1'b0;
            en_next[ptr_reg]  = 1'b0;
        end
    end

    always_comb
    begin
        ov_next       = ov_reg && out_stall;
        kind_next     = kind_reg;
        slot_res_next = slot_res_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        if (emit)
        begin
            ov_next       = 1'b1;
            kind_next     = e_kind;
            slot_res_next = e_slot;
            value_next    = e_val;
            last_next     = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            sw_reg    <= '0;
            live_reg  <= '0;
            run_reg   <= '0;
            en_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            sw_reg    <= sw_next;
            live_reg  <= live_next;
            run_reg   <= run_next;
            en_reg    <= en_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        per_reg      <= per_next;
        rep_reg      <= rep_next;
        rsw_reg      <= rsw_next;
        kind_reg     <= kind_next;
        slot_res_reg <= slot_res_next;
        value_reg    <= value_next;
        last_reg     <= last_next;
    end

    // slot memory: one write port, registered read at the next pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q <= mem[ptr_next];
    end

    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign slot_res  = slot_res_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    `MSTT_NEVER(a_sw_timer_excl, clk, rst_n, |(sw_reg & live_reg))
    `MSTT_NEVER(a_run_needs_sw, clk, rst_n, |((run_reg | en_reg) & ~sw_reg))
    `MSTT_ASSERT(a_ptr_range, clk, rst_n, 32'(ptr_reg) < SLOTS)
    `MSTT_ASSERT(a_busy_no_accept, clk, rst_n, (state_reg != ST_IDLE) |-> in_stall)

endmodule
